@@ hdl/mfpid_pkg.sv @@
// Shared constants, types and register codes of the median-filtered PID position controller.
package mfpid_pkg;

    // Filter window and mechanical stroke.
    localparam int WINDOW    = 15;
    localparam int STROKE_MM = 300;
    localparam int DEADBAND  = 1;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int POS_W    = 12;
    localparam int SUM_W    = 16;
    localparam int GAIN_W   = 8;
    localparam int MM_W     = 9;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 10;

    // Median engine indexing.
    localparam int RING_AW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W          = $clog2(WINDOW + 2);
    localparam int MID_HI         = WINDOW / 2;
    localparam int MID_LO         = (WINDOW > 1) ? WINDOW / 2 - 1 : 0;
    localparam int PTR_AFTER_FILL = 1 % WINDOW;

    // Position mapping and division.
    localparam int QUO_W  = $clog2(((1 << SAMPLE_W) - 1) * STROKE_MM + 1);
    localparam int NUM_W  = QUO_W + 1;
    localparam int DIV_CW = $clog2(QUO_W);

    // PID datapath.
    localparam int PROD_W = GAIN_W + 1 + SUM_W;
    localparam int ACC_W  = PROD_W + 2;

    // Stream widths.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // Register reset values.
    localparam logic [MM_W-1:0]     TARGET_RST   = 9'd100;
    localparam logic [SAMPLE_W-1:0] POT_LOW_RST  = 10'd34;
    localparam logic [SAMPLE_W-1:0] POT_HIGH_RST = 10'd945;
    localparam logic [GAIN_W-1:0]   GAIN_P_RST   = 8'd12;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST   = 8'd0;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST   = 8'd0;
    localparam logic [MM_W-1:0]     IZONE_RST    = 9'd10;
    localparam logic [GAIN_W-1:0]   LIMIT_RST    = 8'd200;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        REG_TARGET   = 3'd0,
        REG_POT_LOW  = 3'd1,
        REG_POT_HIGH = 3'd2,
        REG_GAIN_P   = 3'd3,
        REG_GAIN_I   = 3'd4,
        REG_GAIN_D   = 3'd5,
        REG_IZONE    = 3'd6,
        REG_LIMIT    = 3'd7
    } cfg_reg_t;

    // Completion report of the median engine.
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] median;
    } med_res_t;

    // Completion report of the divider.
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_res_t;

endpackage

@@ hdl/median_filtered_pid_position_control.sv @@
// Top level of the median-filtered PID position controller for one linear actuator.
//
// Usage: one 10-bit potentiometer sample enters per transaction on the s_ channel
// (s_tdata[9:0]). The sample joins a 15-entry window; the window median is mapped to
// millimetres, a PID term is formed against the target and one result transaction
// (direction, duty, position, error) leaves on the m_ channel. When the error is zero
// no result is produced for that sample. Registers are written through cfg_we, cfg_addr
// and cfg_wdata; the user must do so only while the block is idle (not enforced).
// Timing: a sample is taken only while the controller is idle, so the next sample waits
// until the previous one has left the control sequence; the first sample after reset
// fills the window. The two passes over the sorted-window memory and the 19-step divider
// are the longest steps of each later sample.
// Reset: registers return to their defaults, the loop state is cleared and the window
// is marked empty; the window memories are not cleared but filled by the next sample.
// Stall: a result waits in the output register; the next sample is accepted and worked
// on meanwhile, and its result waits until the earlier one has been taken.
module median_filtered_pid_position_control (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata fields from bit 0: pot_sample[9:0], zero fill.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mfpid_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata fields from bit 0: extend_dir[0], duty[8:1], position_mm[20:9],
    // pos_error[32:21], zero fill.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mfpid_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  mfpid_pkg::cfg_reg_t              cfg_addr,
    input  logic [mfpid_pkg::CFG_DW-1:0]      cfg_wdata
);
    import mfpid_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MED  = 8'b0000_0010,
        ST_PREP = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_ERR  = 8'b0001_0000,
        ST_INT  = 8'b0010_0000,
        ST_MAC  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } ctl_state_t;

    ctl_state_t state_reg;

    // Configuration registers.
    logic [MM_W-1:0]     target_reg;
    logic [SAMPLE_W-1:0] pot_low_reg;
    logic [SAMPLE_W-1:0] pot_high_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic [MM_W-1:0]     izone_reg;
    logic [GAIN_W-1:0]   drive_limit_reg;

    // Loop state and datapath registers.
    logic signed [POS_W-1:0]  last_err_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic signed [POS_W-1:0]  err_reg;
    logic signed [POS_W:0]    deriv_reg;
    logic [1:0]               mstep_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic       s_accept;
    med_res_t   med_res;
    div_res_t   div_res;
    logic       div_start;

    logic signed [SAMPLE_W:0]  span;
    logic [SAMPLE_W:0]         span_abs;
    logic signed [SAMPLE_W:0]  med_diff;
    logic signed [31:0]        num_full;
    logic [NUM_W-1:0]          num_abs;
    logic signed [POS_W-1:0]   quo_sat;
    logic signed [POS_W:0]     err_diff;
    logic signed [POS_W-1:0]   err_sat;
    logic [POS_W:0]            mag_full;
    logic [POS_W-1:0]          err_mag;
    logic signed [SUM_W:0]     sum_add;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [SUM_W-1:0]   mul_val;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [ACC_W-1:0]   lim_ext;
    logic signed [ACC_W-1:0]   drive;
    logic signed [ACC_W-1:0]   drive_abs;
    logic                      out_dir;
    logic [GAIN_W-1:0]         out_duty;
    logic                      out_free;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Window median.
    mfpid_median u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .sample  (s_tdata[SAMPLE_W-1:0]),
        .res     (med_res)
    );

    // Position divider.
    mfpid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_abs[QUO_W-1:0]),
        .divisor  (span_abs[SAMPLE_W-1:0]),
        .res      (div_res)
    );

    // Position mapping: numerator, span and saturated signed quotient.
    always_comb begin
        span      = $signed({1'b0, pot_high_reg}) - $signed({1'b0, pot_low_reg});
        span_abs  = span[SAMPLE_W] ? -span : span;
        med_diff  = $signed({1'b0, med_res.median}) - $signed({1'b0, pot_low_reg});
        num_full  = 32'(med_diff) * STROKE_MM;
        num_abs   = num_reg[NUM_W-1] ? -num_reg : num_reg;
        div_start = (state_reg == ST_PREP) && (span != '0);
        if (neg_reg) begin
            quo_sat = (32'(div_res.quotient) > 32'd2048) ? -12'sd2048
                      : -$signed(POS_W'(div_res.quotient));
        end else begin
            quo_sat = (32'(div_res.quotient) > 32'd2047) ? 12'sd2047
                      : $signed(POS_W'(div_res.quotient));
        end
    end

    // Error, its magnitude and the saturated integral.
    always_comb begin
        err_diff = $signed({4'b0, target_reg}) - $signed({pos_reg[POS_W-1], pos_reg});
        if (err_diff > 13'sd2047) begin
            err_sat = 12'sd2047;
        end else if (err_diff < -13'sd2048) begin
            err_sat = -12'sd2048;
        end else begin
            err_sat = err_diff[POS_W-1:0];
        end
        mag_full = err_reg[POS_W-1] ? -{err_reg[POS_W-1], err_reg}
                                    : {err_reg[POS_W-1], err_reg};
        err_mag  = mag_full[POS_W-1:0];
        sum_add  = $signed({sum_reg[SUM_W-1], sum_reg}) + (SUM_W + 1)'(err_reg);
        if (sum_add > 17'sd32767) begin
            sum_sat = 16'sd32767;
        end else if (sum_add < -17'sd32768) begin
            sum_sat = -16'sd32768;
        end else begin
            sum_sat = sum_add[SUM_W-1:0];
        end
    end

    // Shared multiplier: one PID term per step.
    always_comb begin
        case (mstep_reg)
            2'd0: begin
                mul_gain = gain_p_reg;
                mul_val  = SUM_W'(err_reg);
            end
            2'd1: begin
                mul_gain = gain_i_reg;
                mul_val  = sum_reg;
            end
            2'd2: begin
                mul_gain = gain_d_reg;
                mul_val  = SUM_W'(deriv_reg);
            end
            default: begin
                mul_gain = '0;
                mul_val  = '0;
            end
        endcase
        prod_full = $signed({1'b0, mul_gain}) * mul_val;
    end

    // Drive clamp, direction and duty.
    always_comb begin
        lim_ext = $signed({{(ACC_W - GAIN_W){1'b0}}, drive_limit_reg});
        if (acc_reg > lim_ext) begin
            drive = lim_ext;
        end else if (acc_reg < -lim_ext) begin
            drive = -lim_ext;
        end else begin
            drive = acc_reg;
        end
        drive_abs = drive[ACC_W-1] ? -drive : drive;
        out_dir   = !drive[ACC_W-1] && (drive != '0);
        out_duty  = (err_mag <= POS_W'(DEADBAND)) ? '0 : drive_abs[GAIN_W-1:0];
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= TARGET_RST;
            pot_low_reg     <= POT_LOW_RST;
            pot_high_reg    <= POT_HIGH_RST;
            gain_p_reg      <= GAIN_P_RST;
            gain_i_reg      <= GAIN_I_RST;
            gain_d_reg      <= GAIN_D_RST;
            izone_reg       <= IZONE_RST;
            drive_limit_reg <= LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TARGET:   target_reg      <= cfg_wdata[MM_W-1:0];
                REG_POT_LOW:  pot_low_reg     <= cfg_wdata[SAMPLE_W-1:0];
                REG_POT_HIGH: pot_high_reg    <= cfg_wdata[SAMPLE_W-1:0];
                REG_GAIN_P:   gain_p_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_IZONE:    izone_reg       <= cfg_wdata[MM_W-1:0];
                REG_LIMIT:    drive_limit_reg <= cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control sequence and loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_err_reg <= '0;
            sum_reg      <= '0;
            mstep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_MED;
                    end
                end
                ST_MED: begin
                    if (med_res.done) begin
                        num_reg   <= num_full[NUM_W-1:0];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    neg_reg <= num_reg[NUM_W-1] ^ span[SAMPLE_W];
                    if (span == '0) begin
                        pos_reg   <= '0;
                        state_reg <= ST_ERR;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        pos_reg   <= quo_sat;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= err_sat;
                    state_reg <= ST_INT;
                end
                ST_INT: begin
                    if (err_mag < POS_W'(DEADBAND)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        deriv_reg    <= $signed({err_reg[POS_W-1], err_reg})
                                        - $signed({last_err_reg[POS_W-1], last_err_reg});
                        last_err_reg <= err_reg;
                        sum_reg      <= (err_mag <= {3'b0, izone_reg}) ? sum_sat : '0;
                        acc_reg      <= '0;
                        mstep_reg    <= '0;
                        state_reg    <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    prod_reg  <= prod_full;
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg != 2'd0) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    if (mstep_reg == 2'd3) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(OUT_TDATA_W - 2 * POS_W - GAIN_W - 1){1'b0}},
                                         err_reg, pos_reg, out_duty, out_dir};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The median engine reports only while the controller waits for it.
    a_med_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        med_res.done |-> (state_reg == ST_MED))
        else $error("median engine finished outside its wait state");

    // The divider reports only while the controller waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // A finished result is held back while the previous one is still pending.
    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result loaded over a pending transaction");

    // The duty never exceeds the drive limit.
    a_duty_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[GAIN_W:1] <= drive_limit_reg))
        else $error("duty above drive limit");

endmodule

@@ hdl/mfpid_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module mfpid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mfpid_median.sv @@
// Median engine: sample ring memory plus a sorted copy that is updated in two passes.
module mfpid_median (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mfpid_pkg::SAMPLE_W-1:0] sample,
    output mfpid_pkg::med_res_t           res
);
    import mfpid_pkg::*;

    typedef enum logic [4:0] {
        MS_IDLE  = 5'b00001,
        MS_FILL  = 5'b00010,
        MS_OLD   = 5'b00100,
        MS_CNT   = 5'b01000,
        MS_SHIFT = 5'b10000
    } med_state_t;

    med_state_t state_reg;
    logic                primed_reg;
    logic [RING_AW-1:0]  ptr_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] old_reg;
    logic [IDX_W-1:0]    lt_old_reg;
    logic [IDX_W-1:0]    lt_new_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] prev2_reg;
    logic [SAMPLE_W-1:0] med_lo_reg;
    logic [SAMPLE_W-1:0] med_hi_reg;
    logic                done_reg;

    logic                ring_we;
    logic [RING_AW-1:0]  ring_waddr;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                sort_we;
    logic [RING_AW-1:0]  sort_waddr;
    logic [SAMPLE_W-1:0] sort_wdata;
    logic [SAMPLE_W-1:0] sort_rdata;

    logic [IDX_W-1:0]    pos_j;
    logic [IDX_W-1:0]    rm_pos;
    logic [IDX_W-1:0]    ins_pos;
    logic [SAMPLE_W-1:0] c_val;
    logic [SAMPLE_W:0]   med_sum;

    // Ring of raw samples; the read port always looks at the oldest entry.
    mfpid_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_ring_mem (
        .clk   (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    // Sorted copy of the ring contents.
    mfpid_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_sort_mem (
        .clk   (aclk),
        .we    (sort_we),
        .waddr (sort_waddr),
        .wdata (sort_wdata),
        .raddr (idx_reg[RING_AW-1:0]),
        .rdata (sort_rdata)
    );

    // Merge step: the new sorted entry j is drawn from the old entries j-1, j, j+1 or the
    // new sample, given where the evicted value leaves and the new one enters.
    always_comb begin
        pos_j   = idx_reg - IDX_W'(2);
        rm_pos  = lt_old_reg;
        ins_pos = lt_new_reg - IDX_W'(old_reg < sample_reg);
        if (pos_j < ins_pos) begin
            c_val = (pos_j < rm_pos) ? prev_reg : sort_rdata;
        end else if (pos_j == ins_pos) begin
            c_val = sample_reg;
        end else begin
            c_val = (pos_j <= rm_pos) ? prev2_reg : prev_reg;
        end
    end

    // Memory write ports.
    always_comb begin
        ring_we    = (state_reg == MS_FILL) || (state_reg == MS_OLD);
        ring_waddr = (state_reg == MS_FILL) ? idx_reg[RING_AW-1:0] : ptr_reg;
        sort_we    = (state_reg == MS_FILL) ||
                     ((state_reg == MS_SHIFT) && (idx_reg >= IDX_W'(2)));
        sort_waddr = (state_reg == MS_FILL) ? idx_reg[RING_AW-1:0] : pos_j[RING_AW-1:0];
        sort_wdata = (state_reg == MS_FILL) ? sample_reg : c_val;
    end

    // Median of the updated window.
    always_comb begin
        med_sum    = {1'b0, med_lo_reg} + {1'b0, med_hi_reg};
        res.done   = done_reg;
        res.median = (WINDOW % 2 == 1) ? med_hi_reg : med_sum[SAMPLE_W:1];
    end

    // Sequencer: fill on the first sample, else evict, count ranks, rewrite sorted copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MS_IDLE;
            primed_reg <= 1'b0;
            ptr_reg    <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                MS_IDLE: begin
                    if (start) begin
                        sample_reg <= sample;
                        idx_reg    <= '0;
                        state_reg  <= primed_reg ? MS_OLD : MS_FILL;
                    end
                end
                MS_FILL: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(WINDOW - 1)) begin
                        primed_reg <= 1'b1;
                        ptr_reg    <= RING_AW'(PTR_AFTER_FILL);
                        med_lo_reg <= sample_reg;
                        med_hi_reg <= sample_reg;
                        done_reg   <= 1'b1;
                        state_reg  <= MS_IDLE;
                    end
                end
                MS_OLD: begin
                    old_reg    <= ring_rdata;
                    ptr_reg    <= (ptr_reg == RING_AW'(WINDOW - 1)) ? '0
                                  : ptr_reg + RING_AW'(1);
                    idx_reg    <= '0;
                    lt_old_reg <= '0;
                    lt_new_reg <= '0;
                    state_reg  <= MS_CNT;
                end
                MS_CNT: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg != '0) begin
                        lt_old_reg <= lt_old_reg + IDX_W'(sort_rdata < old_reg);
                        lt_new_reg <= lt_new_reg + IDX_W'(sort_rdata < sample_reg);
                    end
                    if (idx_reg == IDX_W'(WINDOW)) begin
                        idx_reg   <= '0;
                        state_reg <= MS_SHIFT;
                    end
                end
                MS_SHIFT: begin
                    prev2_reg <= prev_reg;
                    prev_reg  <= sort_rdata;
                    idx_reg   <= idx_reg + IDX_W'(1);
                    if (idx_reg >= IDX_W'(2)) begin
                        if (pos_j == IDX_W'(MID_HI)) begin
                            med_hi_reg <= c_val;
                        end
                        if (pos_j == IDX_W'(MID_LO)) begin
                            med_lo_reg <= c_val;
                        end
                    end
                    if (idx_reg == IDX_W'(WINDOW + 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= MS_IDLE;
                    end
                end
                default: begin
                    state_reg <= MS_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/mfpid_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module mfpid_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mfpid_pkg::QUO_W-1:0]    dividend,
    input  logic [mfpid_pkg::SAMPLE_W-1:0] divisor,
    output mfpid_pkg::div_res_t           res
);
    import mfpid_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [SAMPLE_W-1:0] dvs_reg;

    logic [SAMPLE_W:0]   shifted;
    logic [SAMPLE_W:0]   trial;
    logic                ge;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        shifted = {rem_reg, quo_reg[QUO_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

endmodule

@@ tb/sv/pid_result_checker.sv @@
// Result checker for the median-filtered PID position controller: predicts and compares.
module pid_result_checker
    import mfpid_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  cfg_reg_t               cfg_addr,
    input  logic [CFG_DW-1:0]      cfg_wdata,
    output int                     pending,
    output int                     fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 100;

    // One result transaction split into its fields.
    typedef struct packed {
        logic                    dir;
        logic [7:0]              duty;
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] err;
    } drive_res_t;

    // Shadow copy of the configuration registers.
    logic [MM_W-1:0]     target_mm;
    logic [SAMPLE_W-1:0] cal_low;
    logic [SAMPLE_W-1:0] cal_high;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   kd;
    logic [MM_W-1:0]     izone_mm;
    logic [GAIN_W-1:0]   drive_max;

    // Shadow copy of the filter window and the loop state.
    logic [SAMPLE_W-1:0]     window [WINDOW];
    logic [RING_AW-1:0]      wr_ptr;
    logic                    filled;
    logic signed [POS_W-1:0] prev_err;
    logic signed [SUM_W-1:0] err_sum;

    drive_res_t expected_drives [$];
    int         mismatches = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Follow register writes, predict on every accepted sample, compare every result.
    always @(posedge aclk) begin
        logic [SAMPLE_W-1:0] srt [WINDOW];
        logic [SAMPLE_W-1:0] v;
        int                  i;
        int                  j;
        longint              med;
        longint              span;
        longint              pos;
        longint              err;
        longint              mag;
        longint              deriv;
        longint              drv;
        drive_res_t          want;
        drive_res_t          got;

        if (!aresetn) begin
            target_mm = TARGET_RST;
            cal_low   = POT_LOW_RST;
            cal_high  = POT_HIGH_RST;
            kp        = GAIN_P_RST;
            ki        = GAIN_I_RST;
            kd        = GAIN_D_RST;
            izone_mm  = IZONE_RST;
            drive_max = LIMIT_RST;
            wr_ptr    = '0;
            filled    = 1'b0;
            prev_err  = '0;
            err_sum   = '0;
            expected_drives.delete();
        end else begin
            // Register write port.
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TARGET:   target_mm = cfg_wdata[MM_W-1:0];
                    REG_POT_LOW:  cal_low   = cfg_wdata[SAMPLE_W-1:0];
                    REG_POT_HIGH: cal_high  = cfg_wdata[SAMPLE_W-1:0];
                    REG_GAIN_P:   kp        = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I:   ki        = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_D:   kd        = cfg_wdata[GAIN_W-1:0];
                    REG_IZONE:    izone_mm  = cfg_wdata[MM_W-1:0];
                    REG_LIMIT:    drive_max = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Sample transaction: update the window and work out the expected drive.
            if (s_tvalid && s_tready) begin
                v = s_tdata[SAMPLE_W-1:0];
                if (!filled) begin
                    for (i = 0; i < WINDOW; i++) begin
                        window[i] = v;
                    end
                    filled = 1'b1;
                end
                if (wr_ptr >= WINDOW) begin
                    wr_ptr = '0;
                end
                window[wr_ptr] = v;
                wr_ptr = RING_AW'((wr_ptr + 1) % WINDOW);

                // Insertion sort of a copy of the window; the median sits in the middle.
                srt = window;
                for (i = 1; i < WINDOW; i++) begin
                    v = srt[i];
                    j = i;
                    while (j > 0 && srt[j-1] > v) begin
                        srt[j] = srt[j-1];
                        j--;
                    end
                    srt[j] = v;
                end
                if (WINDOW % 2 == 1) begin
                    med = longint'(srt[WINDOW/2]);
                end else begin
                    med = (longint'(srt[MID_LO]) + longint'(srt[MID_HI])) / 2;
                end

                // Linear map to millimeters; a zero span gives position zero.
                span = longint'(cal_high) - longint'(cal_low);
                if (span == 0) begin
                    pos = 0;
                end else begin
                    pos = (med - longint'(cal_low)) * STROKE_MM / span;
                end
                pos = clamp(pos, -2048, 2047);
                err = clamp(longint'(target_mm) - pos, -2048, 2047);
                mag = (err < 0) ? -err : err;

                // Inside the deadband the loop state holds and nothing comes out.
                if (mag >= DEADBAND) begin
                    deriv    = err - longint'(prev_err);
                    prev_err = err[POS_W-1:0];
                    if (mag <= longint'(izone_mm) && mag != 0) begin
                        err_sum = SUM_W'(clamp(longint'(err_sum) + err, -32768, 32767));
                    end else begin
                        err_sum = '0;
                    end
                    drv = longint'(kp) * err + longint'(ki) * longint'(err_sum)
                          + longint'(kd) * deriv;
                    drv = clamp(drv, -longint'(drive_max), longint'(drive_max));

                    want.dir = (drv > 0);
                    if (mag <= DEADBAND) begin
                        want.duty = '0;
                    end else begin
                        want.duty = 8'((drv < 0) ? -drv : drv);
                    end
                    want.pos = pos[POS_W-1:0];
                    want.err = err[POS_W-1:0];
                    expected_drives.push_back(want);
                end
            end

            // Result transaction: compare with the oldest expected drive.
            if (m_tvalid && m_tready) begin
                got.dir  = m_tdata[0];
                got.duty = m_tdata[8:1];
                got.pos  = m_tdata[20:9];
                got.err  = m_tdata[32:21];
                if (expected_drives.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: unexpected result, expected none, %s",
                                 $time, "actual below");
                        $display("    actual dir=%0d duty=%0d pos=%0d err=%0d",
                                 got.dir, got.duty, got.pos, got.err);
                    end
                end else begin
                    want = expected_drives.pop_front();
                    if (got.dir !== want.dir || got.duty !== want.duty
                            || got.pos !== want.pos || got.err !== want.err) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: result mismatch, expected dir=%0d duty=%0d %s",
                                     $time, want.dir, want.duty, "(continued)");
                            $display("    expected pos=%0d err=%0d", want.pos, want.err);
                            $display("    actual dir=%0d duty=%0d pos=%0d err=%0d",
                                     got.dir, got.duty, got.pos, got.err);
                        end
                    end
                end
            end
        end

        pending    <= expected_drives.size();
        fail_count <= mismatches;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the testbench: clock, reset, register setup, sample stimulus and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mfpid_pkg::*;

    localparam int PERIOD        = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int NUM_REGS      = 8;
    localparam int RANDOM_PHASES = 9;
    localparam int FIRST_ITEMS   = 150;
    localparam int PHASE_ITEMS   = 100;
    localparam int LIMIT_CYCLES  = 400000;
    // Raw reading that maps to 100 mm with the default calibration.
    localparam int SAMPLE_AT_100 = 339;
    localparam int SAMPLE_MAX    = 1023;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    cfg_reg_t               cfg_addr  = REG_TARGET;
    logic [CFG_DW-1:0]      cfg_wdata = '0;

    int                pending;
    int                fail_count;
    int                stall_left = 0;
    bit                no_idle    = 1'b0;
    int                reg_val [NUM_REGS];

    always #(PERIOD / 2) aclk = ~aclk;

    median_filtered_pid_position_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pid_result_checker result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Result side: after each transaction, stall for a random number of cycles.
    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tready && m_tvalid) begin
            draw = no_idle ? 0 : $urandom_range(3, 0);
            if (draw > 0) begin
                m_tready   <= 1'b0;
                stall_left <= draw - 1;
            end
        end else if (!m_tready) begin
            if (stall_left == 0) begin
                m_tready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    function automatic int clip(int v, int lo, int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Register value that lands on an end of its range now and then.
    function automatic int pick(int hi);
        int r;
        r = $urandom_range(7, 0);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return hi;
        end
        return $urandom_range(hi, 0);
    endfunction

    // Write every register, one per cycle; called only while the block is idle.
    task automatic write_regs();
        cfg_reg_t r;
        int       k;
        r = r.first();
        for (k = 0; k < r.num(); k++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= r;
            cfg_wdata <= CFG_DW'(reg_val[r]);
            @(posedge aclk);
            r = r.next();
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one sample after a random gap and wait for its transaction.
    task automatic send_sample(input int v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(3, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, v[SAMPLE_W-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering samples, wait for every expected result, then let the block finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        #(LIMIT_CYCLES * PERIOD);
        $display("[median_filtered_pid_position_control] ERROR");
        $finish;
    end

    initial begin
        int ph;
        int n;
        int items;
        int base;
        int smp;
        int lo_cal;
        int hi_cal;
        int mode;

        reg_val[REG_TARGET]   = int'(TARGET_RST);
        reg_val[REG_POT_LOW]  = int'(POT_LOW_RST);
        reg_val[REG_POT_HIGH] = int'(POT_HIGH_RST);
        reg_val[REG_GAIN_P]   = int'(GAIN_P_RST);
        reg_val[REG_GAIN_I]   = int'(GAIN_I_RST);
        reg_val[REG_GAIN_D]   = int'(GAIN_D_RST);
        reg_val[REG_IZONE]    = int'(IZONE_RST);
        reg_val[REG_LIMIT]    = int'(LIMIT_RST);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: the first sample fills the window, the error is zero and
        // single outliers do not move the median.
        send_sample(SAMPLE_AT_100);
        send_sample(0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_AT_100);
        settle();

        // Error of plus one millimeter: deadband edge, zero duty.
        reg_val[REG_TARGET] = 101;
        write_regs();
        send_sample(SAMPLE_AT_100);
        send_sample(SAMPLE_AT_100);
        settle();

        // Error of minus one millimeter with the integral and derivative gains at their maximum.
        reg_val[REG_TARGET] = 99;
        reg_val[REG_GAIN_I] = 255;
        reg_val[REG_GAIN_D] = 255;
        reg_val[REG_IZONE]  = 300;
        reg_val[REG_LIMIT]  = 255;
        write_regs();
        send_sample(SAMPLE_AT_100);
        send_sample(SAMPLE_AT_100);
        settle();

        // Far from target with no integral zone and a zero drive bound.
        reg_val[REG_TARGET] = 300;
        reg_val[REG_GAIN_P] = 255;
        reg_val[REG_IZONE]  = 0;
        reg_val[REG_LIMIT]  = 0;
        write_regs();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        settle();

        // Equal calibration readings: zero span, position zero, no result.
        reg_val[REG_TARGET]   = 0;
        reg_val[REG_POT_LOW]  = 512;
        reg_val[REG_POT_HIGH] = 512;
        reg_val[REG_IZONE]    = 300;
        reg_val[REG_LIMIT]    = 255;
        write_regs();
        send_sample(0);
        send_sample(SAMPLE_MAX);
        settle();

        // Reversed calibration readings mirror the mapping.
        reg_val[REG_TARGET]   = 150;
        reg_val[REG_POT_LOW]  = SAMPLE_MAX;
        reg_val[REG_POT_HIGH] = 0;
        write_regs();
        send_sample(0);
        send_sample(SAMPLE_MAX);
        send_sample(0);
        settle();

        // A one-count span drives the position to its upper bound.
        reg_val[REG_TARGET]   = 0;
        reg_val[REG_POT_LOW]  = 0;
        reg_val[REG_POT_HIGH] = 1;
        write_regs();
        send_sample(SAMPLE_AT_100);
        send_sample(SAMPLE_AT_100);
        settle();

        // Position saturates low, so the error saturates high.
        reg_val[REG_POT_LOW]  = 1000;
        reg_val[REG_POT_HIGH] = 1001;
        write_regs();
        send_sample(SAMPLE_AT_100);
        send_sample(SAMPLE_AT_100);
        settle();

        // Random phases. Mode 0 is a slow walk with spikes, mode 1 holds near the
        // target so the deadband is hit, mode 2 is uniform noise.
        base = 512;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode    = ph % 3;
            no_idle = (ph % 4 == 3);
            items   = PHASE_ITEMS;

            reg_val[REG_TARGET] = pick(300);
            reg_val[REG_GAIN_P] = pick(255);
            reg_val[REG_GAIN_I] = pick(255);
            reg_val[REG_GAIN_D] = pick(255);
            reg_val[REG_IZONE]  = pick(300);
            reg_val[REG_LIMIT]  = pick(255);

            lo_cal = $urandom_range(400, 0);
            hi_cal = $urandom_range(SAMPLE_MAX, lo_cal + 1);
            if (ph == 0) begin
                // Long run far from a distant target: the integral reaches its bound.
                lo_cal              = 0;
                hi_cal              = SAMPLE_MAX;
                base                = 0;
                items               = FIRST_ITEMS;
                reg_val[REG_TARGET] = 300;
                reg_val[REG_IZONE]  = 300;
            end else if (ph == 2) begin
                hi_cal = lo_cal;
            end else if (ph == 5) begin
                n      = lo_cal;
                lo_cal = hi_cal;
                hi_cal = n;
            end else if (ph == 8) begin
                lo_cal = $urandom_range(SAMPLE_MAX, 0);
                hi_cal = $urandom_range(SAMPLE_MAX, 0);
            end
            if (mode == 1) begin
                // Target set to where the held reading maps.
                base                = $urandom_range(hi_cal, lo_cal);
                reg_val[REG_TARGET] = (base - lo_cal) * STROKE_MM / (hi_cal - lo_cal);
            end
            reg_val[REG_POT_LOW]  = lo_cal;
            reg_val[REG_POT_HIGH] = hi_cal;
            write_regs();

            for (n = 0; n < items; n++) begin
                case (mode)
                    0: begin
                        base = clip(base + int'($urandom_range(8, 0)) - 4, 0, SAMPLE_MAX);
                        smp  = base;
                    end
                    1: begin
                        smp = clip(base + int'($urandom_range(4, 0)) - 2, 0, SAMPLE_MAX);
                    end
                    default: begin
                        smp = $urandom_range(SAMPLE_MAX, 0);
                    end
                endcase
                if (mode != 2 && $urandom_range(9, 0) == 0) begin
                    smp = $urandom_range(1, 0) ? SAMPLE_MAX : 0;
                end
                send_sample(smp);
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("[median_filtered_pid_position_control] OK");
        end else begin
            $display("[median_filtered_pid_position_control] ERROR");
        end
        $finish;
    end

endmodule
